// File: rtl/line_follow_pid_steer_assert.svh
// assertion macros shared by the checker, sampled on clk_i, off while rst_ni is low
`ifndef LINE_FOLLOW_PID_STEER_ASSERT_SVH
`define LINE_FOLLOW_PID_STEER_ASSERT_SVH

// consequent checked in the same cycle
`define LFPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfps check failed");

// consequent checked in the cycle after the antecedent
`define LFPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfps check failed");

`endif

// File: rtl/lfps_pkg.sv
package lfps_pkg;

  localparam int unsigned SENSORS = 5;
  localparam int unsigned RAW_W = 10;
  localparam int unsigned PCT_W = 7;

  localparam int unsigned SCALE_MUL = 100;
  localparam int unsigned FULL_SCALE = 1023;
  localparam int unsigned INNER_WEIGHT = 40;
  // floor(m * 3277 / 2^16) == m / 20 for m up to 4100
  localparam int unsigned RECIP20 = 3277;
  // floor(y * 1598 / 2^16) is y / 41 or one below it for y up to 8200
  localparam int unsigned RECIP41 = 1598;
  localparam int unsigned MAP_MUL = 20;
  localparam int unsigned MAP_DIV = 41;
  localparam int unsigned D_OFFSET = 205;
  localparam int unsigned E_OFFSET = 100;
  localparam int unsigned GAIN_DIV = 1000;
  localparam int unsigned DRIVE_LIM = 100;
  localparam int unsigned DIV_BITS = 16;
  // floor(r * 68719477 / 2^36) == r / 1000 for r below 2^26
  localparam int unsigned RECIP1000 = 68719477;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned RECIP_W = 27;
  localparam int unsigned QDEPTH = 2;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 17;

  typedef enum logic [1:0] {
    ST_TRACK  = 2'd0,
    ST_FINISH = 2'd1,
    ST_LOST   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_BORDER = 3'd0,
    CFG_BASE   = 3'd1,
    CFG_KP     = 3'd2,
    CFG_KD     = 3'd3,
    CFG_KI     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0]        border;
    logic signed [7:0] base;
    logic [15:0]       kp;
    logic [16:0]       kd;
    logic [15:0]       ki;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    border: 7'd50,
    base:   8'sd40,
    kp:     16'd8000,
    kd:     17'd64000,
    ki:     16'd3
  };

  typedef struct packed {
    status_e           status;
    logic signed [7:0] err;
  } step_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SCALE,
    F_SUM,
    F_QUOT,
    F_MAP,
    F_RECIP,
    F_FIX,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_COMB,
    B_DIV,
    B_DONE
  } back_state_e;

endpackage

// File: rtl/lfps_front.sv
module lfps_front (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              in_valid_i,
  output logic                                              in_stall_o,
  input  logic [lfps_pkg::SENSORS-1:0][lfps_pkg::RAW_W-1:0] raw_i,
  input  logic [6:0]                                        border_i,
  output logic                                              push_o,
  output lfps_pkg::step_t                                   push_data_o,
  input  logic                                              full_i
);

  lfps_pkg::front_state_e state_q, state_d;

  logic [lfps_pkg::SENSORS-1:0][lfps_pkg::RAW_W-1:0] raw_q;
  logic [lfps_pkg::SENSORS-1:0][lfps_pkg::PCT_W-1:0] pct_q, pct_d;
  logic [lfps_pkg::SENSORS-1:0]                      below, above;
  lfps_pkg::status_e                                 status_q, status_d;
  logic [13:0]                                       num_q, num_d;
  logic [12:0]                                       num_mag;
  logic [24:0]                                       quot_prod;
  logic [7:0]                                        quot;
  logic [8:0]                                        d_q, d_d;
  logic [9:0]                                        d_off;
  logic [13:0]                                       y_q, y_d;
  logic [23:0]                                       recip_prod;
  logic [7:0]                                        q0_q, q0_d;
  logic [13:0]                                       map_chk;
  logic [7:0]                                        map_q;
  logic signed [7:0]                                 err_q, err_d;

  // raw * 100 / 1023: shift by 1024 gives the quotient or one below it
  for (genvar k = 0; k < lfps_pkg::SENSORS; k++) begin : g_scale
    logic [16:0] prod;
    logic [6:0]  q0;
    logic [16:0] back_chk;
    assign prod = 17'(raw_q[k]) * 17'(lfps_pkg::SCALE_MUL);
    assign q0 = prod[16:10];
    assign back_chk = (17'(q0) + 17'd1) * 17'(lfps_pkg::FULL_SCALE);
    assign pct_d[k] = (back_chk <= prod) ? q0 + 7'd1 : q0;
    assign below[k] = pct_q[k] < border_i;
    assign above[k] = pct_q[k] > border_i;
  end

  always_comb begin
    if (&below) begin
      status_d = lfps_pkg::ST_FINISH;
    end else if (&above) begin
      status_d = lfps_pkg::ST_LOST;
    end else begin
      status_d = lfps_pkg::ST_TRACK;
    end
  end

  assign num_d = 14'(pct_q[0])
               + 14'(pct_q[1]) * 14'(lfps_pkg::INNER_WEIGHT)
               - 14'(pct_q[3]) * 14'(lfps_pkg::INNER_WEIGHT)
               - 14'(pct_q[4]);

  // divide by 20 on the magnitude, truncating toward zero
  assign num_mag = num_q[13] ? 13'(-num_q) : num_q[12:0];
  assign quot_prod = 25'(num_mag) * 25'(lfps_pkg::RECIP20);
  assign quot = quot_prod[23:16];
  assign d_d = num_q[13] ? 9'(-{1'b0, quot}) : {1'b0, quot};

  assign d_off = {d_q[8], d_q} + 10'(lfps_pkg::D_OFFSET);
  assign y_d = 14'(d_off) * 14'(lfps_pkg::MAP_MUL);

  assign recip_prod = 24'(y_q) * 24'(lfps_pkg::RECIP41);
  assign q0_d = recip_prod[23:16];

  assign map_chk = (14'(q0_q) + 14'd1) * 14'(lfps_pkg::MAP_DIV);
  assign map_q = (map_chk <= y_q) ? q0_q + 8'd1 : q0_q;
  assign err_d = (status_q == lfps_pkg::ST_TRACK) ? (map_q - 8'(lfps_pkg::E_OFFSET)) : 8'sd0;

  assign in_stall_o = (state_q != lfps_pkg::F_IDLE);
  assign push_data_o = '{status: status_q, err: err_q};

  always_comb begin
    state_d = state_q;
    push_o = 1'b0;
    case (state_q)
      lfps_pkg::F_IDLE: begin
        if (in_valid_i) state_d = lfps_pkg::F_SCALE;
      end
      lfps_pkg::F_SCALE: state_d = lfps_pkg::F_SUM;
      lfps_pkg::F_SUM:   state_d = lfps_pkg::F_QUOT;
      lfps_pkg::F_QUOT:  state_d = lfps_pkg::F_MAP;
      lfps_pkg::F_MAP:   state_d = lfps_pkg::F_RECIP;
      lfps_pkg::F_RECIP: state_d = lfps_pkg::F_FIX;
      lfps_pkg::F_FIX:   state_d = lfps_pkg::F_PUSH;
      lfps_pkg::F_PUSH: begin
        if (!full_i) begin
          push_o = 1'b1;
          state_d = lfps_pkg::F_IDLE;
        end
      end
      default: state_d = lfps_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfps_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) raw_q <= raw_i;
    if (state_q == lfps_pkg::F_SCALE) pct_q <= pct_d;
    if (state_q == lfps_pkg::F_SUM) begin
      num_q <= num_d;
      status_q <= status_d;
    end
    if (state_q == lfps_pkg::F_QUOT) d_q <= d_d;
    if (state_q == lfps_pkg::F_MAP) y_q <= y_d;
    if (state_q == lfps_pkg::F_RECIP) q0_q <= q0_d;
    if (state_q == lfps_pkg::F_FIX) err_q <= err_d;
  end

endmodule

// File: rtl/lfps_queue.sv
module lfps_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lfps_pkg::step_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lfps_pkg::step_t pop_data_o
);

  localparam int unsigned PTR_W = $clog2(lfps_pkg::QDEPTH);
  localparam int unsigned CNT_W = $clog2(lfps_pkg::QDEPTH + 1);

  lfps_pkg::step_t mem_q [lfps_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o = (cnt_q == CNT_W'(lfps_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: rtl/lfps_back.sv
module lfps_back #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  lfps_pkg::step_t        data_i,
  output logic                   pop_o,
  input  lfps_pkg::cfg_t         cfg_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [7:0]      left_o,
  output logic signed [7:0]      right_o,
  output logic [1:0]             status_o,
  output logic signed [7:0]      err_o
);

  localparam int unsigned SW = SUM_WIDTH;
  localparam int unsigned HALF = (SW + 1) / 2;
  localparam int unsigned HI_W = SW - HALF;
  localparam int unsigned P1_W = 7 + 16;
  localparam int unsigned P2_W = 8 + 17;
  localparam int unsigned PLO_W = HALF + 16;
  localparam int unsigned PHI_W = HI_W + 16;
  localparam int unsigned PW = SW + 16;
  localparam int unsigned ITER = (PW + lfps_pkg::DIV_BITS - 1) / lfps_pkg::DIV_BITS;
  localparam int unsigned DW = ITER * lfps_pkg::DIV_BITS;
  localparam int unsigned STEPS = 2 * ITER;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned R_W = 10 + lfps_pkg::DIV_BITS;
  localparam int unsigned PROD_W = R_W + lfps_pkg::RECIP_W;
  localparam int unsigned VW = DW + 3;
  localparam int unsigned LANES = 3;
  localparam logic signed [VW-1:0] LIM_HI = VW'(lfps_pkg::DRIVE_LIM);
  localparam logic signed [VW-1:0] LIM_LO = -LIM_HI;

  lfps_pkg::back_state_e state_q, state_d;

  lfps_pkg::step_t       cur_q;
  logic [7:0]            prev_q;
  logic [SW-1:0]         sum_q, sum_d;
  logic [SW:0]           sum_wide;

  logic [6:0]            e_mag;
  logic [8:0]            de;
  logic [7:0]            de_mag;
  logic [SW-1:0]         s_mag;
  logic [P1_W-1:0]       p1_q, p1_d;
  logic [P2_W-1:0]       p2_q, p2_d;
  logic [PLO_W-1:0]      plo_q, plo_d;
  logic [PHI_W-1:0]      phi_q, phi_d;
  logic [LANES-1:0]      neg_q;

  logic [LANES-1:0][DW-1:0]                   dv_q, dv_d;
  logic [LANES-1:0][9:0]                      rem_q, rem_d;
  logic [LANES-1:0][lfps_pkg::DIV_BITS-1:0]   q_q, q_d;
  logic [CNT_W-1:0]                           cnt_q;

  logic signed [VW-1:0]  q_s [LANES];
  logic signed [VW-1:0]  vel, base_s, l_raw, r_raw;

  logic                  out_valid_q, out_valid_d;
  logic                  out_free, load_out;
  logic signed [7:0]     left_q, right_q, err_q;
  logic [1:0]            status_q;

  function automatic logic [7:0] clamp_drive(input logic signed [VW-1:0] v);
    logic [7:0] res;
    if (v > LIM_HI) begin
      res = LIM_HI[7:0];
    end else if (v < LIM_LO) begin
      res = LIM_LO[7:0];
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // magnitudes and signs; each term is truncated toward zero on its own
  assign e_mag = 7'(-cur_q.err);
  assign de = {cur_q.err[7], cur_q.err} - {prev_q[7], prev_q};
  assign de_mag = de[8] ? 8'(-de) : de[7:0];
  assign s_mag = sum_q[SW-1] ? (~sum_q + 1'b1) : sum_q;

  assign p1_d = P1_W'(cur_q.err[7] ? e_mag : cur_q.err[6:0]) * P1_W'(cfg_i.kp);
  assign p2_d = P2_W'(de_mag) * P2_W'(cfg_i.kd);
  // integral product split in two halves to keep each multiplier narrow
  assign plo_d = PLO_W'(s_mag[HALF-1:0]) * PLO_W'(cfg_i.ki);
  assign phi_d = PHI_W'(s_mag[SW-1:HALF]) * PHI_W'(cfg_i.ki);

  // divide by 1000 one 16-bit digit at a time: reciprocal estimate of the digit
  // quotient on even steps, remainder and shift on odd steps
  for (genvar ln = 0; ln < LANES; ln++) begin : g_div
    logic [R_W-1:0]    r;
    logic [PROD_W-1:0] prod;
    logic [R_W-1:0]    qk;

    assign r = {rem_q[ln], dv_q[ln][DW-1 -: lfps_pkg::DIV_BITS]};
    assign prod = PROD_W'(r) * PROD_W'(lfps_pkg::RECIP1000);
    assign q_d[ln] = prod[lfps_pkg::RECIP_SHIFT +: lfps_pkg::DIV_BITS];
    assign qk = R_W'(q_q[ln]) * R_W'(lfps_pkg::GAIN_DIV);
    assign rem_d[ln] = 10'(r - qk);
    assign dv_d[ln] = {dv_q[ln][DW-lfps_pkg::DIV_BITS-1:0], q_q[ln]};

    assign q_s[ln] = neg_q[ln] ? -$signed(VW'(dv_q[ln])) : $signed(VW'(dv_q[ln]));
  end

  assign vel = q_s[0] + q_s[1] + q_s[2];
  assign base_s = $signed({{(VW - 8){cfg_i.base[7]}}, cfg_i.base});
  assign l_raw = base_s - vel;
  assign r_raw = base_s + vel;

  // saturating accumulate of the mapped error
  assign sum_wide = {sum_q[SW-1], sum_q} + {{(SW + 1 - 8){cur_q.err[7]}}, cur_q.err};
  always_comb begin
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_d = sum_wide[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
    end else begin
      sum_d = sum_wide[SW-1:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    pop_o = 1'b0;
    load_out = 1'b0;
    case (state_q)
      lfps_pkg::B_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          state_d = (data_i.status == lfps_pkg::ST_TRACK) ? lfps_pkg::B_MUL : lfps_pkg::B_DONE;
        end
      end
      lfps_pkg::B_MUL:  state_d = lfps_pkg::B_COMB;
      lfps_pkg::B_COMB: state_d = lfps_pkg::B_DIV;
      lfps_pkg::B_DIV: begin
        if (cnt_q == CNT_W'(STEPS - 1)) state_d = lfps_pkg::B_DONE;
      end
      lfps_pkg::B_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d = lfps_pkg::B_IDLE;
        end
      end
      default: state_d = lfps_pkg::B_IDLE;
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfps_pkg::B_IDLE;
      cnt_q <= '0;
      prev_q <= '0;
      sum_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == lfps_pkg::B_COMB) begin
        cnt_q <= '0;
      end else if (state_q == lfps_pkg::B_DIV) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (load_out && (cur_q.status == lfps_pkg::ST_TRACK)) begin
        prev_q <= cur_q.err;
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= data_i;
    if (state_q == lfps_pkg::B_MUL) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      plo_q <= plo_d;
      phi_q <= phi_d;
      neg_q <= {sum_q[SW-1], de[8], cur_q.err[7]};
    end
    if (state_q == lfps_pkg::B_COMB) begin
      dv_q[0] <= DW'(p1_q);
      dv_q[1] <= DW'(p2_q);
      dv_q[2] <= (DW'(phi_q) << HALF) + DW'(plo_q);
      rem_q <= '0;
    end else if (state_q == lfps_pkg::B_DIV) begin
      // even step forms the digit quotient, odd step shifts it in
      if (!cnt_q[0]) begin
        q_q <= q_d;
      end else begin
        dv_q <= dv_d;
        rem_q <= rem_d;
      end
    end
    if (load_out) begin
      status_q <= cur_q.status;
      err_q <= cur_q.err;
      if (cur_q.status == lfps_pkg::ST_TRACK) begin
        left_q <= clamp_drive(l_raw);
        right_q <= clamp_drive(r_raw);
      end else begin
        left_q <= 8'sd0;
        right_q <= 8'sd0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_o = left_q;
  assign right_o = right_q;
  assign status_o = status_q;
  assign err_o = err_q;

endmodule

// File: rtl/line_follow_pid_steer.sv
// front: scale, classify, divide by 20, map by 20/41; one item at a time, push waits on full
// back: finish or lost skip the arithmetic; tracking multiplies, then divides by 1000
//   one 16-bit digit at a time, ceil((SUM_WIDTH + 16) / 16) digits (3 at SUM_WIDTH 32)
// a 2-beat queue sits between front and back
// reset: registers take their reset values, previous error and error sum clear, no result held
module line_follow_pid_steer #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [9:0]                          sensor_0_i,
  input  logic [9:0]                          sensor_1_i,
  input  logic [9:0]                          sensor_2_i,
  input  logic [9:0]                          sensor_3_i,
  input  logic [9:0]                          sensor_4_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [7:0]                   left_drive_o,
  output logic signed [7:0]                   right_drive_o,
  output logic [1:0]                          track_status_o,
  output logic signed [7:0]                   steer_error_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  lfps_pkg::cfg_t  cfg_q, cfg_d;
  lfps_pkg::step_t push_data, pop_data;
  logic            push, full, pop, q_valid;
  logic [lfps_pkg::SENSORS-1:0][lfps_pkg::RAW_W-1:0] raw;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (lfps_pkg::cfg_idx_e'(cfg_index_i))
        lfps_pkg::CFG_BORDER: cfg_d.border = cfg_data_i[6:0];
        lfps_pkg::CFG_BASE:   cfg_d.base = cfg_data_i[7:0];
        lfps_pkg::CFG_KP:     cfg_d.kp = cfg_data_i[15:0];
        lfps_pkg::CFG_KD:     cfg_d.kd = cfg_data_i[16:0];
        lfps_pkg::CFG_KI:     cfg_d.ki = cfg_data_i[15:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lfps_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign raw = {sensor_4_i, sensor_3_i, sensor_2_i, sensor_1_i, sensor_0_i};

  lfps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_i       (raw),
    .border_i    (cfg_q.border),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  lfps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  lfps_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .data_i      (pop_data),
    .pop_o       (pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_o      (left_drive_o),
    .right_o     (right_drive_o),
    .status_o    (track_status_o),
    .err_o       (steer_error_o)
  );

endmodule

// File: rtl/lfps_checker.sv
`include "line_follow_pid_steer_assert.svh"

module lfps_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [7:0] left_drive_o,
  input logic signed [7:0] right_drive_o,
  input logic [1:0]        track_status_o,
  input logic signed [7:0] steer_error_o
);

  // a stalled result beat holds
  `LFPS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(left_drive_o) && $stable(right_drive_o) && $stable(track_status_o) && $stable(steer_error_o))

  // finish and lost beats carry zero drives and zero error
  `LFPS_ASSERT_SAME(a_idle_zero, out_valid_o && (track_status_o != lfps_pkg::ST_TRACK), (left_drive_o == 8'sd0) && (right_drive_o == 8'sd0) && (steer_error_o == 8'sd0))

  `LFPS_ASSERT_SAME(a_drive_range, out_valid_o, (left_drive_o <= 8'sd100) && (left_drive_o >= -8'sd100) && (right_drive_o <= 8'sd100) && (right_drive_o >= -8'sd100))

  `LFPS_ASSERT_SAME(a_err_range, out_valid_o && (track_status_o == lfps_pkg::ST_TRACK), (steer_error_o <= 8'sd100) && (steer_error_o >= -8'sd100))

endmodule

bind line_follow_pid_steer lfps_checker u_lfps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .left_drive_o   (left_drive_o),
  .right_drive_o  (right_drive_o),
  .track_status_o (track_status_o),
  .steer_error_o  (steer_error_o)
);

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int SUM_W = 32;

  typedef logic [4:0][9:0] sensor_set_t;

  typedef struct {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    lfps_pkg::status_e status;
    logic signed [7:0] err;
  } steer_result_t;

  class steer_scoreboard;
    int     border;
    int     base;
    longint kp, kd, ki;
    longint prev_err, err_sum;
    steer_result_t due [$];
    int unsigned failures;

    function new();
      border   = int'(lfps_pkg::CFG_RESET.border);
      base     = int'($signed(lfps_pkg::CFG_RESET.base));
      kp       = longint'(lfps_pkg::CFG_RESET.kp);
      kd       = longint'(lfps_pkg::CFG_RESET.kd);
      ki       = longint'(lfps_pkg::CFG_RESET.ki);
      prev_err = 0;
      err_sum  = 0;
      failures = 0;
    endfunction

    function void write_reg(logic [lfps_pkg::CFG_IDX_W-1:0] idx,
                            logic [lfps_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        lfps_pkg::CFG_BORDER: border = int'(data[6:0]);
        lfps_pkg::CFG_BASE:   base = $signed(data[7:0]);
        lfps_pkg::CFG_KP:     kp = longint'(data[15:0]);
        lfps_pkg::CFG_KD:     kd = longint'(data[16:0]);
        lfps_pkg::CFG_KI:     ki = longint'(data[15:0]);
        default: ;
      endcase
    endfunction

    function longint clip_drive(longint v);
      if (v > 100) return 100;
      if (v < -100) return -100;
      return v;
    endfunction

    // one beat in, one steering result expected
    function void note_sensors(sensor_set_t raw);
      int pct [5];
      bit below, above;
      int d, e;
      longint vel, nsum, smax;
      steer_result_t r;
      below = 1'b1;
      above = 1'b1;
      for (int k = 0; k < 5; k++) begin
        pct[k] = int'(raw[k]) * 100 / 1023;
        below &= (pct[k] < border);
        above &= (pct[k] > border);
      end
      r.left_drive  = '0;
      r.right_drive = '0;
      r.err         = '0;
      r.status      = lfps_pkg::ST_TRACK;
      if (below) begin
        r.status = lfps_pkg::ST_FINISH;
      end else if (above) begin
        r.status = lfps_pkg::ST_LOST;
      end else begin
        d = (pct[0] + 40 * pct[1] - 40 * pct[3] - pct[4]) / 20;
        e = (d + 205) * 200 / 410 - 100;
        vel = longint'(e) * kp / 1000 + (longint'(e) - prev_err) * kd / 1000
            + err_sum * ki / 1000;
        r.left_drive  = 8'(clip_drive(base - vel));
        r.right_drive = 8'(clip_drive(base + vel));
        r.err         = 8'(e);
        prev_err = e;
        smax = (longint'(1) <<< (SUM_W - 1)) - 1;
        nsum = err_sum + e;
        if (nsum > smax) nsum = smax;
        if (nsum < -smax - 1) nsum = -smax - 1;
        err_sum = nsum;
      end
      due.push_back(r);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic signed [7:0] lft, logic signed [7:0] rgt,
                               logic [1:0] st, logic signed [7:0] e);
      steer_result_t x;
      if (due.size() == 0) begin
        flag($sformatf("unexpected result: left %0d right %0d status %0d err %0d",
                       lft, rgt, st, e));
        return;
      end
      x = due.pop_front();
      if (lft !== x.left_drive || rgt !== x.right_drive || st !== x.status ||
          e !== x.err)
        flag($sformatf({"mismatch exp/got: left %0d/%0d right %0d/%0d ",
                        "status %0d/%0d err %0d/%0d"},
                       x.left_drive, lft, x.right_drive, rgt, x.status, st, x.err, e));
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [9:0]                      sensor_0_i = '0;
  logic [9:0]                      sensor_1_i = '0;
  logic [9:0]                      sensor_2_i = '0;
  logic [9:0]                      sensor_3_i = '0;
  logic [9:0]                      sensor_4_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic signed [7:0]               left_drive_o;
  logic signed [7:0]               right_drive_o;
  logic [1:0]                      track_status_o;
  logic signed [7:0]               steer_error_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [lfps_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  bit calm = 1'b0;
  steer_scoreboard sb = new();

  line_follow_pid_steer #(.SUM_WIDTH(SUM_W)) dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 11);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(left_drive_o, right_drive_o, track_status_o, steer_error_o);
  end

  function automatic sensor_set_t set5(int a, int b, int c, int d, int e);
    return {10'(e), 10'(d), 10'(c), 10'(b), 10'(a)};
  endfunction

  function automatic sensor_set_t random_set();
    sensor_set_t s;
    int unsigned pick, spot;
    pick = $urandom_range(99);
    for (int k = 0; k < 5; k++) s[k] = 10'($urandom_range(1023));
    if (pick < 20) begin
      // dark floor with a bright line under one or two neighboring sensors
      spot = $urandom_range(4);
      for (int k = 0; k < 5; k++) s[k] = 10'($urandom_range(250));
      s[spot] = 10'($urandom_range(1023, 750));
      if ($urandom_range(1) == 1 && spot < 4) s[spot + 1] = 10'($urandom_range(1023, 750));
    end else if (pick < 30) begin
      for (int k = 0; k < 5; k++) s[k] = 10'($urandom_range(300));
    end else if (pick < 38) begin
      for (int k = 0; k < 5; k++) s[k] = 10'($urandom_range(1023, 700));
    end else if (pick < 48) begin
      for (int k = 0; k < 5; k++) s[k] = $urandom_range(1) ? 10'd1023 : 10'd0;
    end
    return s;
  endfunction

  // called right after a rising edge, returns right after the accepting edge
  task automatic send_item(input sensor_set_t raw);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sensor_0_i <= raw[0];
    sensor_1_i <= raw[1];
    sensor_2_i <= raw[2];
    sensor_3_i <= raw[3];
    sensor_4_i <= raw[4];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sensors(raw);
  endtask

  task automatic write_reg(input logic [lfps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lfps_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input int ph);
    int unsigned bl, p, dv, ig;
    int bs;
    bl = $urandom_range(100);
    bs = int'($urandom_range(255)) - 128;
    p  = $urandom_range(65535);
    dv = $urandom_range(131071);
    ig = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(50);
    case (ph)
      0: begin
        bl = 0; bs = -128; p = 65535; dv = 131071; ig = 65535;
      end
      1: begin
        bl = 100; bs = 127; p = 0; dv = 0; ig = 0;
      end
      // threshold above full scale, every set reads as finish
      2: bl = $urandom_range(127, 101);
      3: bs = -100;
      4: bs = 100;
      default: ;
    endcase
    // unused upper data bits carry noise, the block must drop them
    write_reg(lfps_pkg::CFG_BORDER, 17'(($urandom << 7) | bl));
    write_reg(lfps_pkg::CFG_BASE, 17'(($urandom << 8) | (bs & 8'hff)));
    write_reg(lfps_pkg::CFG_KP, 17'(($urandom << 16) | p));
    write_reg(lfps_pkg::CFG_KD, 17'(dv));
    write_reg(lfps_pkg::CFG_KI, 17'(($urandom << 16) | ig));
    if (ph == 2 || ph == 6) begin
      for (int ix = int'(lfps_pkg::CFG_KI) + 1; ix < (1 << lfps_pkg::CFG_IDX_W); ix++)
        write_reg(lfps_pkg::CFG_IDX_W'(ix), 17'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    sensor_set_t probe [$];
    probe.push_back(set5(0, 0, 0, 0, 0));
    probe.push_back(set5(1023, 1023, 1023, 1023, 1023));
    probe.push_back(set5(512, 512, 512, 512, 512));
    probe.push_back(set5(511, 511, 511, 511, 511));
    probe.push_back(set5(513, 513, 513, 513, 513));
    probe.push_back(set5(524, 524, 524, 524, 524));
    probe.push_back(set5(1023, 0, 0, 0, 0));
    probe.push_back(set5(0, 1023, 0, 0, 0));
    probe.push_back(set5(0, 0, 1023, 0, 0));
    probe.push_back(set5(0, 0, 0, 1023, 0));
    probe.push_back(set5(0, 0, 0, 0, 1023));
    // full swings left and right for the largest derivative steps
    probe.push_back(set5(1023, 1023, 0, 0, 0));
    probe.push_back(set5(0, 0, 0, 1023, 1023));
    probe.push_back(set5(1023, 1023, 0, 0, 0));
    probe.push_back(set5(0, 0, 0, 1023, 1023));
    probe.push_back(set5(1023, 1023, 0, 1023, 1023));
    probe.push_back(set5(10'h2aa, 10'h155, 10'h2aa, 10'h155, 10'h2aa));
    probe.push_back(set5(10'h155, 10'h2aa, 10'h155, 10'h2aa, 10'h155));
    probe.push_back(set5(0, 1023, 1023, 1023, 0));
    probe.push_back(set5(1023, 0, 512, 0, 1023));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe[i]) send_item(probe[i]);
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      while (sb.pending() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      configure(ph);
      calm = (ph == 4);
      repeat ((ph == 2) ? 25 : 145) send_item(random_set());
      in_valid_i <= 1'b0;
      calm = 1'b0;
    end

    for (int w = 0; w < 20000 && sb.pending() != 0; w++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("line_follow_pid_steer regression: pass");
    end else begin
      $display("line_follow_pid_steer regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("line_follow_pid_steer regression: fail");
    $finish;
  end

endmodule
